// File: hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Command and result codes, the result record, the control and status
// groups between the top level and the pattern unit, and the hex decoder.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Default pattern capacity in bytes
  localparam int unsigned PATTERN_MAX_DEF = 64;

  // Depth of the result queue; one item can add two results
  localparam int unsigned RES_DEPTH = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_TARGET_INDEX = 2'd1;
  localparam logic [1:0] CFG_ALL_MATCHES  = 2'd2;

  // ASCII codes used by the pattern loader
  localparam logic [7:0] ASCII_QMARK = 8'h3F;
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_UA    = 8'h41;
  localparam logic [7:0] ASCII_UF    = 8'h46;
  localparam logic [7:0] ASCII_LA    = 8'h61;
  localparam logic [7:0] ASCII_LF    = 8'h66;
  localparam logic [3:0] HEX_TEN     = 4'hA;

  // Saturation limit of the match counter
  localparam logic [15:0] MATCH_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PCHAR = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_MATCH     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_NOT_FOUND = 2'd2,
    KIND_ODD       = 2'd3
  } kind_e;

  // One result record
  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [15:0] num;
    logic        sel;
    logic [15:0] total;
    logic        last;
  } res_t;

  // Control from the top level to the pattern unit
  typedef struct packed {
    logic clr;
    logic char_we;
    logic byte_we;
  } pat_ctl_t;

  // Status from the pattern unit
  typedef struct packed {
    logic odd;
    logic win_ok;
  } pat_stat_t;

  // Decoded hex character
  typedef struct packed {
    logic       vld;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h = '0;
    case (c) inside
      [ASCII_0:ASCII_9]: begin
        h.vld = 1'b1;
        h.val = 4'(c - ASCII_0);
      end
      [ASCII_UA:ASCII_UF]: begin
        h.vld = 1'b1;
        h.val = 4'(c - ASCII_UA) + HEX_TEN;
      end
      [ASCII_LA:ASCII_LF]: begin
        h.vld = 1'b1;
        h.val = 4'(c - ASCII_LA) + HEX_TEN;
      end
      default: h = '0;
    endcase
    return h;
  endfunction

endpackage

// File: hdl/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner: wildcard byte pattern search over a stream
// Loads a hex text pattern with '?' wildcards and reports masked matches.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result queue has room: a
// request sits in an input register, where the whole pattern is compared with
// the byte window in parallel, and its results enter a four-entry result
// queue that drives the output port. A request that gives two results (a
// match on the last region byte followed by the end result) hands them out in
// turn; every other request gives at most one. The input side stalls only when
// the result queue cannot hold two more results. Configuration is written
// through cfg_we_i at any clock edge.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
  parameter int unsigned PatternMax = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  pattern_char_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_region_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] match_address_o,
  output logic [15:0] match_number_o,
  output logic        selected_o,
  output logic [15:0] total_matches_o,
  output logic        final_res_o
);

  localparam int unsigned SizeW = $clog2(PatternMax + 1);

  // Configuration registers
  logic [31:0] base_q;
  logic [15:0] target_q;
  logic        all_q;

  // Input register
  logic                in_vld_q;
  mbps_pkg::cmd_e      cmd_q;
  logic [7:0]          pchar_q;
  logic [7:0]          dbyte_q;
  logic                eor_q;

  // Scan state
  logic [31:0] bs_q, bs_d;
  logic [15:0] mc_q, mc_d;
  logic        stop_q, stop_d;

  // Pattern unit and result queue
  mbps_pkg::pat_ctl_t  pctl;
  mbps_pkg::pat_stat_t pstat;
  logic [SizeW-1:0]    size;
  logic [1:0]          push_n;
  mbps_pkg::res_t      res_a, res_b, res_end, head;
  logic                q_nempty, q_room;

  logic        proc_go;
  logic        in_take;
  logic [31:0] bs_new;
  logic [15:0] mc_hit;
  logic        hit;
  logic        sel;
  logic        stop_hit;
  logic [31:0] start;

  assign proc_go    = in_vld_q && q_room;
  assign in_ready_o = !in_vld_q || proc_go;
  assign in_take    = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      target_q <= '0;
      all_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbps_pkg::CFG_BASE_ADDRESS: base_q   <= cfg_data_i;
        mbps_pkg::CFG_TARGET_INDEX: target_q <= cfg_data_i[15:0];
        mbps_pkg::CFG_ALL_MATCHES:  all_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (proc_go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= mbps_pkg::cmd_e'(cmd_i);
      pchar_q <= pattern_char_i;
      dbyte_q <= data_byte_i;
      eor_q   <= end_of_region_i;
    end
  end

  // Scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q   <= '0;
      mc_q   <= '0;
      stop_q <= 1'b0;
    end else begin
      bs_q   <= bs_d;
      mc_q   <= mc_d;
      stop_q <= stop_d;
    end
  end

  // Window hit, match ordinal and start address
  assign bs_new   = bs_q + 32'd1;
  assign mc_hit   = (mc_q != mbps_pkg::MATCH_MAX) ? mc_q + 16'd1 : mc_q;
  assign hit      = (size == '0) || ((bs_new >= 32'(size)) && pstat.win_ok);
  assign start    = (size == '0) ? bs_q : bs_new - 32'(size);
  assign sel      = (target_q == 16'd0) || (target_q == mc_hit) || all_q;
  assign stop_hit = hit && sel && !all_q;

  // Request processing
  always_comb begin
    pctl    = '0;
    bs_d    = bs_q;
    mc_d    = mc_q;
    stop_d  = stop_q;
    push_n  = 2'd0;
    res_a   = '0;
    res_b   = '0;
    res_end = '0;
    if (proc_go) begin
      case (cmd_q)
        mbps_pkg::CMD_CLEAR: begin
          pctl.clr = 1'b1;
          bs_d     = '0;
          mc_d     = '0;
          stop_d   = 1'b0;
        end
        mbps_pkg::CMD_PCHAR: begin
          pctl.char_we = 1'b1;
        end
        mbps_pkg::CMD_DATA: begin
          if (!stop_q) begin
            if (pstat.odd) begin
              // half-entered pattern byte: report and stop
              res_a.kind  = mbps_pkg::KIND_ODD;
              res_a.total = mc_q;
              res_a.last  = 1'b1;
              push_n      = 2'd1;
              stop_d      = 1'b1;
            end else begin
              pctl.byte_we = 1'b1;
              bs_d         = bs_new;
              res_end.kind = all_q ? mbps_pkg::KIND_DONE : mbps_pkg::KIND_NOT_FOUND;
              res_end.total = hit ? mc_hit : mc_q;
              res_end.last  = 1'b1;
              if (hit) begin
                mc_d        = mc_hit;
                res_a.kind  = mbps_pkg::KIND_MATCH;
                res_a.addr  = base_q + start;
                res_a.num   = mc_hit;
                res_a.sel   = sel;
                res_a.total = mc_hit;
                res_a.last  = !eor_q || stop_hit;
                push_n      = 2'd1;
                if (stop_hit) begin
                  stop_d = 1'b1;
                end
              end
              // end of region result unless the target match stopped us
              if (eor_q && !stop_hit) begin
                stop_d = 1'b1;
                if (hit) begin
                  res_b  = res_end;
                  push_n = 2'd2;
                end else begin
                  res_a  = res_end;
                  push_n = 2'd1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  mbps_pattern #(
    .PatternMax (PatternMax)
  ) u_pattern (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (pctl),
    .pattern_char_i (pchar_q),
    .data_byte_i    (dbyte_q),
    .size_o         (size),
    .stat_o         (pstat)
  );

  mbps_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res_a_i  (res_a),
    .res_b_i  (res_b),
    .pop_i    (out_valid_o && out_ready_i),
    .head_o   (head),
    .nempty_o (q_nempty),
    .room_o   (q_room)
  );

  // Result port
  assign out_valid_o     = q_nempty;
  assign kind_o          = head.kind;
  assign match_address_o = head.addr;
  assign match_number_o  = head.num;
  assign selected_o      = head.sel;
  assign total_matches_o = head.total;
  assign final_res_o     = head.last;

endmodule

// File: hdl/mbps_pattern.sv
// ----------------------------------------------------------------------------
// mbps_pattern: pattern store, byte window and masked window compare
// The pattern is kept right-aligned to the window: each completed pattern
// byte shifts in at position 0, so pattern byte i sits opposite window byte
// size-1-i and the compare is one parallel masked equality over all slots.
// ----------------------------------------------------------------------------
module mbps_pattern #(
  parameter int unsigned PatternMax = mbps_pkg::PATTERN_MAX_DEF,
  localparam int unsigned SizeW = $clog2(PatternMax + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbps_pkg::pat_ctl_t  ctl_i,
  input  logic [7:0]          pattern_char_i,
  input  logic [7:0]          data_byte_i,
  output logic [SizeW-1:0]    size_o,
  output mbps_pkg::pat_stat_t stat_o
);

  localparam int unsigned NibW = SizeW + 1;

  logic [NibW-1:0]       nib_q;
  logic [PatternMax-1:0] mask_q;
  logic                  hwild_q;
  logic [3:0]            hi_q;
  logic [7:0]            pat_q [PatternMax];
  logic [PatternMax-1:0] wild_q;
  logic [7:0]            win_q [PatternMax];

  mbps_pkg::hex_t        hex;
  logic                  is_qmark;
  logic                  full;
  logic                  take;
  logic                  push;
  logic [7:0]            shift_byte;
  logic                  push_wild;
  logic [PatternMax-1:0] slot_ok;

  // Character decode; nibbles beyond a full pattern are dropped
  assign hex        = mbps_pkg::hex_decode(pattern_char_i);
  assign is_qmark   = (pattern_char_i == mbps_pkg::ASCII_QMARK);
  assign full       = (nib_q >= NibW'(2 * PatternMax));
  assign take       = ctl_i.char_we && !full && (hex.vld || is_qmark);
  assign push       = take && nib_q[0];
  assign shift_byte = {hi_q, (hex.vld ? hex.val : 4'h0)};
  assign push_wild  = hwild_q || is_qmark;

  // Nibble count, occupancy mask and pending wildcard mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_q   <= '0;
      mask_q  <= '0;
      hwild_q <= 1'b0;
    end else if (ctl_i.clr) begin
      nib_q   <= '0;
      mask_q  <= '0;
      hwild_q <= 1'b0;
    end else if (take) begin
      nib_q <= nib_q + NibW'(1);
      if (nib_q[0]) begin
        hwild_q <= 1'b0;
        mask_q[0] <= 1'b1;
        for (int j = 1; j < PatternMax; j++) begin
          mask_q[j] <= mask_q[j-1];
        end
      end else begin
        hwild_q <= is_qmark;
      end
    end
  end

  // Pattern bytes, wildcard marks and staged high nibble
  always_ff @(posedge clk_i) begin
    if (take && !nib_q[0]) begin
      hi_q <= hex.val;
    end
    if (push) begin
      pat_q[0]  <= shift_byte;
      wild_q[0] <= push_wild;
      for (int j = 1; j < PatternMax; j++) begin
        pat_q[j]  <= pat_q[j-1];
        wild_q[j] <= wild_q[j-1];
      end
    end
  end

  // Byte window, newest byte at slot 0
  always_ff @(posedge clk_i) begin
    if (ctl_i.byte_we) begin
      win_q[0] <= data_byte_i;
      for (int j = 1; j < PatternMax; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  // Masked compare against the window as it is after this byte
  always_comb begin
    slot_ok[0] = !mask_q[0] || wild_q[0] || (data_byte_i == pat_q[0]);
    for (int j = 1; j < PatternMax; j++) begin
      slot_ok[j] = !mask_q[j] || wild_q[j] || (win_q[j-1] == pat_q[j]);
    end
  end

  assign size_o        = nib_q[NibW-1:1];
  assign stat_o.odd    = nib_q[0];
  assign stat_o.win_ok = &slot_ok;

endmodule

// File: hdl/mbps_res_fifo.sv
// ----------------------------------------------------------------------------
// mbps_res_fifo: result queue
// Takes zero, one or two results per cycle and hands them out in order.
// ----------------------------------------------------------------------------
module mbps_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  mbps_pkg::res_t      res_a_i,
  input  mbps_pkg::res_t      res_b_i,
  input  logic                pop_i,
  output mbps_pkg::res_t      head_o,
  output logic                nempty_o,
  output logic                room_o
);

  localparam int unsigned Depth = mbps_pkg::RES_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);

  mbps_pkg::res_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [PtrW:0]   cnt_q;
  logic [PtrW-1:0] wr_nxt;

  assign wr_nxt = wr_q + PtrW'(1);

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= res_a_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nxt] <= res_b_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_n_i);
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_n_i) - (PtrW+1)'(pop_i);
    end
  end

  assign head_o   = mem_q[rd_q];
  assign nempty_o = (cnt_q != '0);
  assign room_o   = (cnt_q <= (PtrW+1)'(Depth - 2));

endmodule

// File: verif/masked_byte_pattern_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb: self-checking bench for the pattern scanner
// Loads hex text patterns with wildcards, streams region bytes under random
// handshake idling, and predicts every result record in the bench. Each
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;
  import mbps_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned PMAX         = PATTERN_MAX_DEF;
  localparam int unsigned PLANT_MAX    = PMAX + 2;   // over-long patterns
  localparam int unsigned DRAIN_CYCLES = 6;          // drain margin after the last result
  // Watchdog bound on the whole run, set with margin for heavy idling and
  // up to two results per request.
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned PRINT_MAX    = 40;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [7:0]  pattern_char_i;
  logic [7:0]  data_byte_i;
  logic        end_of_region_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [31:0] match_address_o;
  logic [15:0] match_number_o;
  logic        selected_o;
  logic [15:0] total_matches_o;
  logic        final_res_o;

  // Scanner state mirror and register copies
  logic [7:0]  pat_byte  [PMAX];
  bit          pat_wild  [PMAX];
  logic [7:0]  nibbles;
  logic [7:0]  window_q  [PMAX];
  logic [31:0] bytes_in;
  logic [15:0] hit_count;
  bit          halted;
  logic [31:0] cfg_base;
  logic [15:0] cfg_target;
  bit          cfg_all;

  // Predicted results, oldest first
  res_t expected_results [$];
  res_t head;

  // Bookkeeping
  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent   = 0;
  int unsigned scans_run       = 0;
  int unsigned cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned rx_hold_cycles  = 0;

  masked_byte_pattern_scanner DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .pattern_char_i  (pattern_char_i),
    .data_byte_i     (data_byte_i),
    .end_of_region_i (end_of_region_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .match_address_o (match_address_o),
    .match_number_o  (match_number_o),
    .selected_o      (selected_o),
    .total_matches_o (total_matches_o),
    .final_res_o     (final_res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result receiver: random idling, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Print the first few mismatches, count all of them
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_MAX)
      $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h",
               results_checked, what, got, want);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("arrived with nothing expected, kind", 32'(kind_o), 32'd0);
      end else begin
        head = expected_results.pop_front();
        if (kind_o !== head.kind)
          report_mismatch("kind", 32'(kind_o), 32'(head.kind));
        if (match_address_o !== head.addr)
          report_mismatch("match_address", match_address_o, head.addr);
        if (match_number_o !== head.num)
          report_mismatch("match_number", 32'(match_number_o), 32'(head.num));
        if (selected_o !== head.sel)
          report_mismatch("selected", 32'(selected_o), 32'(head.sel));
        if (total_matches_o !== head.total)
          report_mismatch("total_matches", 32'(total_matches_o), 32'(head.total));
        if (final_res_o !== head.last)
          report_mismatch("final_res", 32'(final_res_o), 32'(head.last));
      end
      results_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Scanner prediction
  // --------------------------------------------------------------------------

  function automatic bit hex_digit(input logic [7:0] ch, output logic [3:0] val);
    val = 4'h0;
    if (ch >= ASCII_0 && ch <= ASCII_9) begin
      val = 4'(ch - ASCII_0);
      return 1'b1;
    end
    if (ch >= ASCII_UA && ch <= ASCII_UF) begin
      val = 4'(ch - ASCII_UA) + HEX_TEN;
      return 1'b1;
    end
    if (ch >= ASCII_LA && ch <= ASCII_LF) begin
      val = 4'(ch - ASCII_LA) + HEX_TEN;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_scan_state();
    int i;
    for (i = 0; i < PMAX; i++) begin
      pat_byte[i] = 8'h00;
      pat_wild[i] = 1'b0;
      window_q[i] = 8'h00;
    end
    nibbles   = 8'd0;
    bytes_in  = 32'd0;
    hit_count = 16'd0;
    halted    = 1'b0;
  endtask

  task automatic push_result(input kind_e k, input logic [31:0] addr,
                             input logic [15:0] num, input logic sel,
                             input logic last);
    res_t r;
    r.kind  = k;
    r.addr  = addr;
    r.num   = num;
    r.sel   = sel;
    r.total = hit_count;
    r.last  = last;
    expected_results.push_back(r);
  endtask

  // Update the mirror for one accepted request and queue its results
  task automatic predict_request(input cmd_e cmd, input logic [7:0] ch,
                                 input logic [7:0] by, input logic eor);
    logic [3:0]  digit;
    int unsigned idx;
    int unsigned pat_len;
    int          i;
    bit          hit;
    bit          sel;
    logic [31:0] win_start;
    case (cmd)
      CMD_CLEAR: clear_scan_state();
      CMD_PCHAR: begin
        // characters beyond a full pattern are dropped
        idx = nibbles >> 1;
        if (nibbles < 2 * PMAX) begin
          if (hex_digit(ch, digit)) begin
            if (!nibbles[0]) pat_byte[idx] |= {digit, 4'h0};
            else pat_byte[idx] |= {4'h0, digit};
            nibbles++;
          end else if (ch == ASCII_QMARK) begin
            pat_wild[idx] = 1'b1;
            nibbles++;
          end
        end
      end
      CMD_DATA: begin
        if (!halted) begin
          if (nibbles[0]) begin
            // half a byte left over: refuse the scan
            push_result(KIND_ODD, 32'd0, 16'd0, 1'b0, 1'b1);
            halted = 1'b1;
          end else begin
            for (i = PMAX - 1; i > 0; i--) window_q[i] = window_q[i - 1];
            window_q[0] = by;
            bytes_in++;
            pat_len   = nibbles >> 1;
            hit       = 1'b0;
            win_start = 32'd0;
            if (pat_len == 0) begin
              hit       = 1'b1;
              win_start = bytes_in - 32'd1;
            end else if (bytes_in >= pat_len) begin
              hit = 1'b1;
              for (i = 0; i < pat_len; i++)
                if (!pat_wild[i] && window_q[pat_len - 1 - i] != pat_byte[i]) hit = 1'b0;
              win_start = bytes_in - pat_len;
            end
            if (hit) begin
              if (hit_count != MATCH_MAX) hit_count++;
              sel = (cfg_target == 16'd0) || (cfg_target == hit_count) || cfg_all;
              push_result(KIND_MATCH, cfg_base + win_start, hit_count, sel,
                          (sel && !cfg_all) || !eor);
              if (sel && !cfg_all) halted = 1'b1;
            end
            if (eor && !halted) begin
              push_result(cfg_all ? KIND_DONE : KIND_NOT_FOUND, 32'd0, 16'd0, 1'b0, 1'b1);
              halted = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one request after a random gap and wait until it is taken
  task automatic send_request(input cmd_e cmd, input logic [7:0] ch,
                              input logic [7:0] by, input logic eor);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    pattern_char_i  <= ch;
    data_byte_i     <= by;
    end_of_region_i <= eor;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(cmd, ch, by, eor);
    if (cmd != CMD_NONE) requests_sent++;
  endtask

  // Stop offering, wait for every predicted result, then let the pipe empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BASE_ADDRESS: cfg_base   = value;
      CFG_TARGET_INDEX: cfg_target = value[15:0];
      CFG_ALL_MATCHES:  cfg_all    = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < HEX_TEN) return ASCII_0 + 8'(v);
    return (upper ? ASCII_UA : ASCII_LA) + 8'(v - HEX_TEN);
  endfunction

  // Any character the pattern loader skips
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    logic [3:0] unused;
    do c = 8'($urandom_range(255)); while (hex_digit(c, unused) || c == ASCII_QMARK);
    return c;
  endfunction

  function automatic logic [7:0] random_hex_char();
    return hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
  endfunction

  // Random register settings, extremes included; upper data bits are junk
  task automatic randomize_config();
    logic [31:0] base;
    logic [15:0] target;
    settle();
    case ($urandom_range(3))
      0:       base = 32'h0000_0000;
      1:       base = 32'hFFFF_FFFF;
      default: base = $urandom;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: target = 16'd0;
      8:          target = 16'hFFFF;
      9:          target = 16'($urandom_range(65535));
      default:    target = 16'($urandom_range(1, 4));
    endcase
    write_register(CFG_BASE_ADDRESS, base);
    write_register(CFG_TARGET_INDEX, {16'($urandom), target});
    write_register(CFG_ALL_MATCHES, {31'($urandom), 1'($urandom_range(1))});
  endtask

  // One pattern load plus one region, mostly well formed, with some noise
  task automatic run_random_scan();
    int unsigned pat_len;
    int unsigned reg_len;
    int unsigned plants;
    int unsigned off;
    int unsigned pick;
    int unsigned i;
    int unsigned j;
    logic [7:0]  pat_val [PLANT_MAX];
    bit          pat_mask [PLANT_MAX];
    logic [7:0]  region [$];
    logic        eor;
    // mostly short patterns, now and then a long one that can overfill the store
    case ($urandom_range(29))
      0:       pat_len = 0;
      1:       pat_len = $urandom_range(PMAX - 4, PLANT_MAX);
      default: pat_len = $urandom_range(1, 4);
    endcase
    for (i = 0; i < pat_len; i++) begin
      pat_mask[i] = ($urandom_range(5) == 0);
      pat_val[i]  = 8'($urandom_range(255));
    end
    if ($urandom_range(9) != 0)
      send_request(CMD_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));

    // pattern text
    for (i = 0; i < pat_len; i++) begin
      if ($urandom_range(9) == 0)
        send_request(CMD_PCHAR, noise_char(), 8'($urandom_range(255)), 1'($urandom_range(1)));
      if (pat_mask[i]) begin
        // wildcard byte, possibly holding a digit in one nibble
        pick = $urandom_range(2);
        send_request(CMD_PCHAR, (pick == 2) ? random_hex_char() : ASCII_QMARK,
                     8'($urandom_range(255)), 1'b0);
        send_request(CMD_PCHAR, (pick == 1) ? random_hex_char() : ASCII_QMARK,
                     8'($urandom_range(255)), 1'b0);
      end else begin
        send_request(CMD_PCHAR, hex_char(pat_val[i][7:4], 1'($urandom_range(1))),
                     8'($urandom_range(255)), 1'b0);
        send_request(CMD_PCHAR, hex_char(pat_val[i][3:0], 1'($urandom_range(1))),
                     8'($urandom_range(255)), 1'b0);
      end
    end
    if ($urandom_range(14) == 0)
      send_request(CMD_PCHAR, random_hex_char(), 8'($urandom_range(255)), 1'b0);

    // region with planted copies of the pattern
    reg_len = (pat_len == 0) ? $urandom_range(1, 6) : pat_len + $urandom_range(0, 10);
    for (j = 0; j < reg_len; j++)
      region.push_back((pat_len > 0 && $urandom_range(1) == 1) ?
                       pat_val[$urandom_range(pat_len - 1)] : 8'($urandom_range(255)));
    plants = (pat_len == 0) ? 0 : $urandom_range(0, 2);
    repeat (plants) begin
      off = $urandom_range(0, reg_len - pat_len);
      for (i = 0; i < pat_len; i++)
        region[off + i] = pat_mask[i] ? 8'($urandom_range(255)) : pat_val[i];
    end
    for (j = 0; j < reg_len; j++) begin
      case ($urandom_range(39))
        0: send_request(CMD_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        1'($urandom_range(1)));
        1: send_request(CMD_PCHAR, ($urandom_range(1) == 1) ? random_hex_char() :
                        8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
        default: ;
      endcase
      eor = (j == reg_len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
      send_request(CMD_DATA, 8'($urandom_range(255)), region[j], eor);
    end
    scans_run++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All-matches mode: empty pattern, wildcards, ignored characters, odd
  // pattern, address wrap and pattern growth in the middle of a scan
  task automatic test_directed_all_mode();
    settle();
    write_register(CFG_ALL_MATCHES, 32'd1);
    write_register(CFG_BASE_ADDRESS, 32'hFFFF_FFFE);
    write_register(CFG_TARGET_INDEX, 32'd0);
    // unused command with every field at its top value
    send_request(CMD_NONE, 8'hFF, 8'hFF, 1'b1);
    // empty pattern matches every byte at itself
    send_request(CMD_DATA, 8'h00, 8'h00, 1'b0);
    send_request(CMD_DATA, 8'hFF, 8'hFF, 1'b1);
    send_request(CMD_DATA, 8'h00, 8'h5A, 1'b1);   // scan already ended
    send_request(CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    // "Ff" then a wildcard byte that also holds a 9; junk in between
    send_request(CMD_PCHAR, "F", 8'h00, 1'b0);
    send_request(CMD_PCHAR, "f", 8'h00, 1'b0);
    send_request(CMD_PCHAR, "G", 8'h00, 1'b0);
    send_request(CMD_PCHAR, 8'h00, 8'h00, 1'b0);
    send_request(CMD_PCHAR, 8'hFF, 8'h00, 1'b0);
    send_request(CMD_PCHAR, ASCII_QMARK, 8'h00, 1'b0);
    send_request(CMD_PCHAR, "9", 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'hFF, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'hFF, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h77, 1'b0);   // address wraps to zero
    send_request(CMD_DATA, 8'h00, 8'h3A, 1'b1);
    // a single digit leaves the pattern odd
    send_request(CMD_CLEAR, 8'hFF, 8'hFF, 1'b1);
    send_request(CMD_PCHAR, "1", 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h00, 1'b0);
    // pattern extended while the region streams
    send_request(CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    send_request(CMD_PCHAR, "1", 8'h00, 1'b0);
    send_request(CMD_PCHAR, "2", 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h12, 1'b0);
    send_request(CMD_PCHAR, "3", 8'h00, 1'b0);
    send_request(CMD_PCHAR, "4", 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h12, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h34, 1'b1);
  endtask

  // Target mode: stop on the chosen match, first match, and not found
  task automatic test_target_select();
    settle();
    write_register(CFG_ALL_MATCHES, 32'd0);
    write_register(CFG_BASE_ADDRESS, 32'd0);
    write_register(CFG_TARGET_INDEX, 32'd2);
    send_request(CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'hAA, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'hBB, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'hCC, 1'b1);
    settle();
    write_register(CFG_TARGET_INDEX, 32'd0);
    send_request(CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h11, 1'b0);
    settle();
    write_register(CFG_TARGET_INDEX, 32'h0000_FFFF);
    send_request(CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    send_request(CMD_DATA, 8'h00, 8'h00, 1'b1);
  endtask

  task automatic test_random_scans(input int unsigned count);
    int unsigned first;
    first = requests_sent;
    while (requests_sent - first < count) begin
      if ($urandom_range(2) == 0) randomize_config();
      run_random_scan();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the result
  // queue fills and the input stalls
  task automatic test_backpressure();
    int i;
    settle();
    write_register(CFG_ALL_MATCHES, 32'd1);
    send_request(CMD_CLEAR, 8'h00, 8'h00, 1'b0);
    settle();
    rx_hold_cycles = 300;
    for (i = 0; i < 40; i++)
      send_request(CMD_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)), i == 39);
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_BASE_ADDRESS;
    cfg_data_i      = 32'd0;
    in_valid_i      = 1'b0;
    cmd_i           = CMD_NONE;
    pattern_char_i  = 8'h00;
    data_byte_i     = 8'h00;
    end_of_region_i = 1'b0;
    out_ready_i     = 1'b0;
    clear_scan_state();
    cfg_base   = 32'd0;
    cfg_target = 16'd0;
    cfg_all    = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 17;
    recv_idle_pct = 86;
    test_directed_all_mode();
    test_target_select();
    test_random_scans(330);
    // roles swapped
    send_idle_pct = 86;
    recv_idle_pct = 17;
    test_random_scans(330);
    // full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_scans(340);
    test_backpressure();
    settle();

    $display("Checked %0d results from %0d requests: directed cases and %0d random scans,",
             results_checked, requests_sent, scans_run);
    $display("plus a long receiver stall that fills the block and holds its input.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mbps_pkg.sv
hdl/mbps_pattern.sv
hdl/mbps_res_fifo.sv
hdl/masked_byte_pattern_scanner.sv
verif/masked_byte_pattern_scanner_tb.sv
